// File: hw/rtl/mpfd_pkg.sv
`timescale 1ns / 1ps

package mpfd_pkg;

	localparam int CMD_W  = 3;
	localparam int PAGE_W = 4;

	localparam logic [CMD_W-1:0] CMD_PUT_PIXEL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GET_PIXEL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FILL_ALL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BOX_SOLID = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RECT_EDGE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ_BYTE = 3'd5;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_PAGES  = 2'd2;

	localparam logic [7:0] RST_WIDTH  = 8'd128;
	localparam logic [6:0] RST_HEIGHT = 7'd64;
	localparam logic [3:0] RST_PAGES  = 4'd8;

	localparam logic [7:0] BYTE_ALL = 8'hFF;
	localparam logic [7:0] BIT_LOW  = 8'h01;
	localparam logic [2:0] ROW_LAST = 3'h7;

	typedef enum logic [1:0] {
		OP_SOLID,
		OP_EDGE,
		OP_GET_PIXEL,
		OP_READ_BYTE
	} op_t;

endpackage

// File: hw/rtl/mono_page_framebuffer_draw_unit.sv
`timescale 1ns / 1ps
// channel | signals                                         | direction
// input   | in_valid, in_ready, cmd, pos_x, pos_y,          | in
//         | box_width, box_height, color, byte_index        |
// output  | out_valid, out_ready, pixel_value, data_byte    | out
// config  | cfg_we, cfg_index, cfg_data                     | in
// set pixel, get pixel and read byte each touch one store byte; fill and rectangles
// touch one store byte for each page and column in range, one per cycle, through the
// read-modify-write path of the frame memory (read port, then write port)
// after reset a clearing pass writes MAX_WIDTH * MAX_PAGES bytes, one per cycle,
// before the first item is accepted
// a result waiting at the output does not block intake; a result read waits in the walk
module mono_page_framebuffer_draw_unit #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_PAGES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [7:0]  box_width,
	input  logic [7:0]  box_height,
	input  logic        color,
	input  logic [9:0]  byte_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pixel_value,
	output logic [7:0]  data_byte,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_PAGES;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [7:0] mem [DEPTH];

	logic [7:0] width_q;
	logic [6:0] height_q;
	logic [3:0] pages_q;

	logic [1:0]    state_q;
	logic [AW-1:0] clr_addr_q;

	mpfd_pkg::op_t op_q;
	logic                      color_q;
	logic                      zero_q;
	logic [7:0]                col_q;
	logic [7:0]                col_lo_q;
	logic [7:0]                col_hi_q;
	logic [mpfd_pkg::PAGE_W-1:0] page_q;
	logic [mpfd_pkg::PAGE_W-1:0] page_lo_q;
	logic [mpfd_pkg::PAGE_W-1:0] page_hi_q;
	logic [2:0]                row_lo_q;
	logic [2:0]                row_hi_q;
	logic [AW-1:0]             base_q;
	logic [AW-1:0]             bidx_q;
	logic [8:0]                uw_q;

	logic          wr_s1;
	logic          res_s1;
	logic          byte_s1;
	logic          zero_s1;
	logic          color_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    mask_s1;
	logic [2:0]    bit_s1;
	logic [7:0]    rdata_s1;

	logic       out_valid_q;
	logic       pixel_q;
	logic [7:0] byte_q;

	// used display size
	logic [8:0] uw;
	logic [4:0] up;
	logic [7:0] lim;
	logic [7:0] uh;
	always_comb begin
		uw  = ({1'b0, width_q} < 9'(MAX_WIDTH)) ? {1'b0, width_q} : 9'(MAX_WIDTH);
		up  = ({1'b0, pages_q} < 5'(MAX_PAGES)) ? {1'b0, pages_q} : 5'(MAX_PAGES);
		lim = 8'({up, 3'b000});
		uh  = ({1'b0, height_q} < lim) ? {1'b0, height_q} : lim;
	end

	// command decode and clipping
	logic                        pix_ok;
	logic                        rect_ok;
	logic [9:0]                  xe_sum;
	logic [9:0]                  ye_sum;
	logic [7:0]                  xe_c;
	logic [7:0]                  ye_c;
	logic [12:0]                 prod;
	logic [AW+9:0]               bidx_ext;
	logic                        bidx_ok;
	logic                        go;
	mpfd_pkg::op_t               op_d;
	logic [7:0]                  col_lo_d;
	logic [7:0]                  col_hi_d;
	logic [mpfd_pkg::PAGE_W-1:0] page_lo_d;
	logic [mpfd_pkg::PAGE_W-1:0] page_hi_d;
	logic [2:0]                  row_lo_d;
	logic [2:0]                  row_hi_d;
	logic [AW-1:0]               base_d;
	logic                        zero_d;
	always_comb begin
		pix_ok   = ({1'b0, pos_x} < uw) && (pos_y < uh);
		rect_ok  = pix_ok && (box_width != 8'd0) && (box_height != 8'd0);
		xe_sum   = {2'b00, pos_x} + {2'b00, box_width} - 10'd1;
		ye_sum   = {2'b00, pos_y} + {2'b00, box_height} - 10'd1;
		xe_c     = (xe_sum > {1'b0, uw - 9'd1}) ? 8'(uw - 9'd1) : xe_sum[7:0];
		ye_c     = (ye_sum > {2'b00, uh - 8'd1}) ? (uh - 8'd1) : ye_sum[7:0];
		prod     = 13'(pos_y[6:3]) * 13'(uw);
		bidx_ext = {{AW{1'b0}}, byte_index};
		bidx_ok  = (32'(byte_index) < DEPTH);
		go        = 1'b0;
		op_d      = mpfd_pkg::OP_SOLID;
		col_lo_d  = pos_x;
		col_hi_d  = pos_x;
		page_lo_d = pos_y[6:3];
		page_hi_d = pos_y[6:3];
		row_lo_d  = pos_y[2:0];
		row_hi_d  = pos_y[2:0];
		base_d    = prod[AW-1:0];
		zero_d    = 1'b0;
		case (cmd)
			mpfd_pkg::CMD_PUT_PIXEL: begin
				go = pix_ok;
			end
			mpfd_pkg::CMD_GET_PIXEL: begin
				go     = 1'b1;
				op_d   = mpfd_pkg::OP_GET_PIXEL;
				zero_d = !pix_ok;
			end
			mpfd_pkg::CMD_FILL_ALL: begin
				go        = (uw != 9'd0) && (up != 5'd0);
				col_lo_d  = 8'd0;
				col_hi_d  = 8'(uw - 9'd1);
				page_lo_d = '0;
				page_hi_d = 4'(up - 5'd1);
				row_lo_d  = 3'd0;
				row_hi_d  = mpfd_pkg::ROW_LAST;
				base_d    = '0;
			end
			mpfd_pkg::CMD_BOX_SOLID, mpfd_pkg::CMD_RECT_EDGE: begin
				go        = rect_ok;
				op_d      = (cmd == mpfd_pkg::CMD_RECT_EDGE) ? mpfd_pkg::OP_EDGE
				                                             : mpfd_pkg::OP_SOLID;
				col_hi_d  = xe_c;
				page_hi_d = ye_c[6:3];
				row_hi_d  = ye_c[2:0];
			end
			mpfd_pkg::CMD_READ_BYTE: begin
				go        = 1'b1;
				op_d      = mpfd_pkg::OP_READ_BYTE;
				zero_d    = !bidx_ok;
				col_lo_d  = 8'd0;
				col_hi_d  = 8'd0;
				page_lo_d = '0;
				page_hi_d = '0;
			end
			default: begin
				go = 1'b0;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	logic accept;
	assign accept = in_valid && in_ready;

	// walk step: one store byte per cycle, held for a read while a result waits unaccepted
	logic          is_read;
	logic          issue;
	logic          last_col;
	logic          last_page;
	logic [2:0]    lo_b;
	logic [2:0]    hi_b;
	logic [7:0]    span_mask;
	logic [7:0]    edge_mask;
	logic [7:0]    mask_d;
	logic [AW-1:0] rd_addr;
	always_comb begin
		is_read   = (op_q == mpfd_pkg::OP_GET_PIXEL) || (op_q == mpfd_pkg::OP_READ_BYTE);
		issue     = (state_q == ST_WALK) && (!is_read || !out_valid_q || out_ready);
		last_col  = (col_q == col_hi_q);
		last_page = (page_q == page_hi_q);
		lo_b      = (page_q == page_lo_q) ? row_lo_q : 3'd0;
		hi_b      = (page_q == page_hi_q) ? row_hi_q : mpfd_pkg::ROW_LAST;
		span_mask = (mpfd_pkg::BYTE_ALL << lo_b) &
		            (mpfd_pkg::BYTE_ALL >> (mpfd_pkg::ROW_LAST - hi_b));
		edge_mask = ((page_q == page_lo_q) ? (mpfd_pkg::BIT_LOW << row_lo_q) : 8'd0) |
		            ((page_q == page_hi_q) ? (mpfd_pkg::BIT_LOW << row_hi_q) : 8'd0);
		if (op_q == mpfd_pkg::OP_EDGE && col_q != col_lo_q && col_q != col_hi_q) begin
			mask_d = edge_mask;
		end else begin
			mask_d = span_mask;
		end
		rd_addr = (op_q == mpfd_pkg::OP_READ_BYTE) ? bidx_q
		                                            : base_q + AW'(col_q);
	end

	// write port: clearing pass or write-back of the byte read last cycle
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	always_comb begin
		wr_en   = (state_q == ST_CLEAR) || wr_s1;
		wr_addr = (state_q == ST_CLEAR) ? clr_addr_q : addr_s1;
		wr_data = (state_q == ST_CLEAR) ? 8'd0
		        : ((rdata_s1 & ~mask_s1) | (color_s1 ? mask_s1 : 8'd0));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mpfd_pkg::RST_WIDTH;
			height_q <= mpfd_pkg::RST_HEIGHT;
			pages_q  <= mpfd_pkg::RST_PAGES;
		end else if (cfg_we) begin
			case (cfg_index)
				mpfd_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				mpfd_pkg::CFG_HEIGHT: height_q <= cfg_data[6:0];
				mpfd_pkg::CFG_PAGES:  pages_q  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && go) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (issue && last_col && last_page) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_d;
			color_q   <= color;
			zero_q    <= zero_d;
			col_q     <= col_lo_d;
			col_lo_q  <= col_lo_d;
			col_hi_q  <= col_hi_d;
			page_q    <= page_lo_d;
			page_lo_q <= page_lo_d;
			page_hi_q <= page_hi_d;
			row_lo_q  <= row_lo_d;
			row_hi_q  <= row_hi_d;
			base_q    <= base_d;
			bidx_q    <= bidx_ext[AW-1:0];
			uw_q      <= uw;
		end else if (issue) begin
			if (last_col) begin
				col_q  <= col_lo_q;
				page_q <= page_q + mpfd_pkg::PAGE_W'(1);
				base_q <= base_q + AW'(uw_q);
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1  <= 1'b0;
			res_s1 <= 1'b0;
		end else begin
			wr_s1  <= issue && !is_read;
			res_s1 <= issue && is_read;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			byte_s1  <= (op_q == mpfd_pkg::OP_READ_BYTE);
			zero_s1  <= zero_q;
			color_s1 <= color_q;
			addr_s1  <= rd_addr;
			mask_s1  <= mask_d;
			bit_s1   <= row_lo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s1) begin
			pixel_q <= !byte_s1 && !zero_s1 && rdata_s1[bit_s1];
			byte_q  <= (byte_s1 && !zero_s1) ? rdata_s1 : 8'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;
	assign data_byte   = byte_q;

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1 |-> (!out_valid_q || out_ready))
		else $error("result overwrites a pending item");

	a_no_walk_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!wr_s1 && !res_s1 && !in_ready))
		else $error("store access during clearing pass");

	a_issue_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> (wr_s1 || res_s1))
		else $error("store read lost before write-back");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (32'(addr_s1) < DEPTH))
		else $error("write-back address beyond store");

endmodule
